// ===== hdl/sesort_pkg.sv =====
// Shared definitions for the string exchange sorter: default sizes, microcode
// opcodes, jump conditions, step addresses and the microcode ROM.
// Used by sesort_seq, sesort_dp and string_exchange_sort_top; depends on nothing.
package sesort_pkg;

  localparam int MAX_STRINGS_DEF = 8;
  localparam int MAX_LEN_DEF     = 64;
  localparam int CHAR_W          = 8;
  localparam int OUT_IDX_W       = 3;

  localparam int OP_W   = 5;
  localparam int COND_W = 4;
  localparam int STEP_W = 5;

  // Datapath operations, one per control word.
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_CLR_I    = 5'd1;
  localparam logic [OP_W-1:0] OP_INIT_ORD = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_OI    = 5'd3;
  localparam logic [OP_W-1:0] OP_LD_OI    = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_OJ    = 5'd5;
  localparam logic [OP_W-1:0] OP_LD_OJ    = 5'd6;
  localparam logic [OP_W-1:0] OP_LD_LA    = 5'd7;
  localparam logic [OP_W-1:0] OP_LD_LB    = 5'd8;
  localparam logic [OP_W-1:0] OP_CMP      = 5'd9;
  localparam logic [OP_W-1:0] OP_SWAP_I   = 5'd10;
  localparam logic [OP_W-1:0] OP_SWAP_J   = 5'd11;
  localparam logic [OP_W-1:0] OP_INC_J    = 5'd12;
  localparam logic [OP_W-1:0] OP_INC_I    = 5'd13;
  localparam logic [OP_W-1:0] OP_RD_OUT   = 5'd14;
  localparam logic [OP_W-1:0] OP_PUSH     = 5'd15;
  localparam logic [OP_W-1:0] OP_FINISH   = 5'd16;

  // Jump conditions. A true condition loads the target, otherwise the step advances.
  localparam logic [COND_W-1:0] COND_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] COND_NOT_START = 4'd2;
  localparam logic [COND_W-1:0] COND_INIT_MORE = 4'd3;
  localparam logic [COND_W-1:0] COND_N_ONE     = 4'd4;
  localparam logic [COND_W-1:0] COND_CONT      = 4'd5;
  localparam logic [COND_W-1:0] COND_NOT_GT    = 4'd6;
  localparam logic [COND_W-1:0] COND_J_MORE    = 4'd7;
  localparam logic [COND_W-1:0] COND_I_MORE    = 4'd8;
  localparam logic [COND_W-1:0] COND_OUT_BUSY  = 4'd9;
  localparam logic [COND_W-1:0] COND_EMIT_MORE = 4'd10;

  // Step addresses of the microprogram.
  localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] S_INIT_CLR  = 5'd1;
  localparam logic [STEP_W-1:0] S_INIT_LOOP = 5'd2;
  localparam logic [STEP_W-1:0] S_SORT_CLR  = 5'd3;
  localparam logic [STEP_W-1:0] S_OUTER     = 5'd4;
  localparam logic [STEP_W-1:0] S_LOAD_OI   = 5'd5;
  localparam logic [STEP_W-1:0] S_INNER     = 5'd6;
  localparam logic [STEP_W-1:0] S_LOAD_OJ   = 5'd7;
  localparam logic [STEP_W-1:0] S_LOAD_LA   = 5'd8;
  localparam logic [STEP_W-1:0] S_READ_TXT  = 5'd9;
  localparam logic [STEP_W-1:0] S_CMP       = 5'd10;
  localparam logic [STEP_W-1:0] S_TEST      = 5'd11;
  localparam logic [STEP_W-1:0] S_SWAP_I    = 5'd12;
  localparam logic [STEP_W-1:0] S_SWAP_J    = 5'd13;
  localparam logic [STEP_W-1:0] S_NEXT_J    = 5'd14;
  localparam logic [STEP_W-1:0] S_NEXT_I    = 5'd15;
  localparam logic [STEP_W-1:0] S_EMIT_CLR  = 5'd16;
  localparam logic [STEP_W-1:0] S_EMIT_RD   = 5'd17;
  localparam logic [STEP_W-1:0] S_EMIT_PUSH = 5'd18;
  localparam logic [STEP_W-1:0] S_EMIT_NEXT = 5'd19;
  localparam logic [STEP_W-1:0] S_DONE      = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic            busy;
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic init_more;
    logic n_one;
    logic cont;
    logic gt;
    logic j_more;
    logic i_more;
    logic out_busy;
    logic emit_more;
  } stat_t;

  function automatic ucw_t ucw(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                               input logic [STEP_W-1:0] target);
    ucw_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    case (step)
      S_IDLE:      w = ucw(OP_NONE,     COND_NOT_START, S_IDLE);
      S_INIT_CLR:  w = ucw(OP_CLR_I,    COND_NEVER,     S_IDLE);
      S_INIT_LOOP: w = ucw(OP_INIT_ORD, COND_INIT_MORE, S_INIT_LOOP);
      S_SORT_CLR:  w = ucw(OP_CLR_I,    COND_N_ONE,     S_EMIT_CLR);
      S_OUTER:     w = ucw(OP_RD_OI,    COND_NEVER,     S_IDLE);
      S_LOAD_OI:   w = ucw(OP_LD_OI,    COND_NEVER,     S_IDLE);
      S_INNER:     w = ucw(OP_RD_OJ,    COND_NEVER,     S_IDLE);
      S_LOAD_OJ:   w = ucw(OP_LD_OJ,    COND_NEVER,     S_IDLE);
      S_LOAD_LA:   w = ucw(OP_LD_LA,    COND_NEVER,     S_IDLE);
      S_READ_TXT:  w = ucw(OP_LD_LB,    COND_NEVER,     S_IDLE);
      S_CMP:       w = ucw(OP_CMP,      COND_CONT,      S_READ_TXT);
      S_TEST:      w = ucw(OP_NONE,     COND_NOT_GT,    S_NEXT_J);
      S_SWAP_I:    w = ucw(OP_SWAP_I,   COND_NEVER,     S_IDLE);
      S_SWAP_J:    w = ucw(OP_SWAP_J,   COND_NEVER,     S_IDLE);
      S_NEXT_J:    w = ucw(OP_INC_J,    COND_J_MORE,    S_INNER);
      S_NEXT_I:    w = ucw(OP_INC_I,    COND_I_MORE,    S_OUTER);
      S_EMIT_CLR:  w = ucw(OP_CLR_I,    COND_NEVER,     S_IDLE);
      S_EMIT_RD:   w = ucw(OP_RD_OUT,   COND_NEVER,     S_IDLE);
      S_EMIT_PUSH: w = ucw(OP_PUSH,     COND_OUT_BUSY,  S_EMIT_PUSH);
      S_EMIT_NEXT: w = ucw(OP_NONE,     COND_EMIT_MORE, S_EMIT_RD);
      S_DONE:      w = ucw(OP_FINISH,   COND_ALWAYS,    S_IDLE);
      default:     w = ucw(OP_NONE,     COND_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/string_exchange_sort_top.sv =====
// Top level of the string exchange sorter: loads strings a character at a time,
// sorts their load positions and streams them out.
// Depends on sesort_pkg, sesort_seq and sesort_dp.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, in_char_code,              | into block
//           | in_last_of_string, in_last_of_set              |
//   result  | out_valid, out_stall, out_string_index,        | out of block
//           | out_last_of_run                                |
//
// Loading takes one cycle per character word; in_stall is high while a set is sorted
// and emitted. The microcode sequencer first sets up the order list, then on each outer
// pass reads and loads order entry i, and per pair loads entry j and both lengths,
// compares the byte positions one at a time and swaps the entries if needed; the
// memories are read through registers. Emitting clears the index, then reads and pushes
// each index when out_stall allows, then finishes.
// Reset (rst_n low, synchronous) clears the string count, the sequencer and out_valid;
// memories are not cleared. A held result stays in the output register while new
// character words are taken.
module string_exchange_sort_top #(
  parameter int MAX_STRINGS = sesort_pkg::MAX_STRINGS_DEF,
  parameter int MAX_LEN     = sesort_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sesort_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                             in_last_of_string,
  input  logic                             in_last_of_set,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sesort_pkg::OUT_IDX_W-1:0] out_string_index,
  output logic                             out_last_of_run
);

  sesort_pkg::ctrl_t ctrl;
  sesort_pkg::stat_t stat;

  sesort_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  sesort_dp #(
    .MAX_STRINGS(MAX_STRINGS),
    .MAX_LEN    (MAX_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_char_code     (in_char_code),
    .in_last_of_string(in_last_of_string),
    .in_last_of_set   (in_last_of_set),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_string_index (out_string_index),
    .out_last_of_run  (out_last_of_run),
    .out_stall        (out_stall)
  );

  assign in_stall = ctrl.busy;

endmodule

// ===== hdl/sesort_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on sesort_pkg for the ROM, opcodes, conditions and the status/control structs.
module sesort_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  sesort_pkg::stat_t   stat,
  output sesort_pkg::ctrl_t   ctrl
);

  logic [sesort_pkg::STEP_W-1:0] step_r;
  logic [sesort_pkg::STEP_W-1:0] step_nxt;
  sesort_pkg::ucw_t              word;
  logic                          take;

  assign word = sesort_pkg::ucode_rom(step_r);

  always_comb begin
    case (word.cond)
      sesort_pkg::COND_NEVER:     take = 1'b0;
      sesort_pkg::COND_ALWAYS:    take = 1'b1;
      sesort_pkg::COND_NOT_START: take = !stat.start;
      sesort_pkg::COND_INIT_MORE: take = stat.init_more;
      sesort_pkg::COND_N_ONE:     take = stat.n_one;
      sesort_pkg::COND_CONT:      take = stat.cont;
      sesort_pkg::COND_NOT_GT:    take = !stat.gt;
      sesort_pkg::COND_J_MORE:    take = stat.j_more;
      sesort_pkg::COND_I_MORE:    take = stat.i_more;
      sesort_pkg::COND_OUT_BUSY:  take = stat.out_busy;
      sesort_pkg::COND_EMIT_MORE: take = stat.emit_more;
      default:                    take = 1'b1;
    endcase
  end

  assign step_nxt = take ? word.target : step_r + sesort_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sesort_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.busy = (step_r != sesort_pkg::S_IDLE);
  assign ctrl.op   = word.op;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= sesort_pkg::S_DONE)
    else $error("sequencer step outside the microprogram");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == sesort_pkg::S_IDLE) && !stat.start |=> step_r == sesort_pkg::S_IDLE)
    else $error("sequencer left idle without a set end");

endmodule

// ===== hdl/sesort_dp.sv =====
// Datapath of the string sorter: character loader, text/length/order memories,
// index registers, byte comparator and the result register.
// Depends on sesort_pkg; driven by sesort_seq through ctrl_t, reports through stat_t.
module sesort_dp #(
  parameter int MAX_STRINGS = sesort_pkg::MAX_STRINGS_DEF,
  parameter int MAX_LEN     = sesort_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [sesort_pkg::CHAR_W-1:0]   in_char_code,
  input  logic                            in_last_of_string,
  input  logic                            in_last_of_set,
  input  sesort_pkg::ctrl_t               ctrl,
  output sesort_pkg::stat_t               stat,
  output logic                            out_valid,
  output logic [sesort_pkg::OUT_IDX_W-1:0] out_string_index,
  output logic                            out_last_of_run,
  input  logic                            out_stall
);

  localparam int CW        = $clog2(MAX_STRINGS + 1);
  localparam int IW        = $clog2(MAX_STRINGS);
  localparam int LW        = $clog2(MAX_LEN);
  localparam int TXT_DEPTH = MAX_STRINGS * MAX_LEN;
  localparam int AW        = $clog2(TXT_DEPTH);
  localparam int CHW       = sesort_pkg::CHAR_W;
  localparam int OW        = sesort_pkg::OUT_IDX_W;

  logic [CHW-1:0] text_mem [TXT_DEPTH];
  logic [LW-1:0]  len_mem  [MAX_STRINGS];
  logic [IW-1:0]  ord_mem  [MAX_STRINGS];

  // Loader state.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] pos_r, pos_nxt;

  // Sort registers.
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic [IW-1:0]  oi_r, oi_nxt;
  logic [IW-1:0]  oj_r, oj_nxt;
  logic [LW-1:0]  la_r, la_nxt;
  logic [LW-1:0]  lb_r, lb_nxt;
  logic           gt_r, gt_nxt;
  logic [IW-1:0]  ord_rd_r;
  logic [LW-1:0]  len_rd_r;
  logic [CHW-1:0] ta_r, tb_r;

  logic           out_valid_r, out_valid_nxt;
  logic [OW-1:0]  out_idx_r;
  logic           out_last_r;

  logic           load_acc, room, keep, end_str;
  logic [LW-1:0]  pos_inc;
  logic [IW-1:0]  ld_idx;
  logic [AW-1:0]  text_waddr, ta_addr, tb_addr;
  logic           text_we, len_we, text_re, len_re;
  logic [IW-1:0]  len_raddr;
  logic           ord_we, ord_re;
  logic [IW-1:0]  ord_waddr, ord_wdata, ord_raddr;
  logic [CHW-1:0] x_byte, y_byte;
  logic           out_free, push;

  // ---------------- loader ----------------
  assign load_acc = in_valid && !ctrl.busy;
  assign room     = cnt_r < CW'(MAX_STRINGS);
  assign keep     = pos_r < LW'(MAX_LEN - 1);
  assign end_str  = in_last_of_string || in_last_of_set;
  assign pos_inc  = pos_r + LW'(1);
  assign ld_idx   = cnt_r[IW-1:0];

  assign text_waddr = AW'(ld_idx) * AW'(MAX_LEN) + AW'(pos_r);
  assign text_we    = load_acc && room && keep;
  assign len_we     = load_acc && room && end_str;

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (ctrl.op == sesort_pkg::OP_FINISH) begin
      cnt_nxt = '0;
      pos_nxt = '0;
    end else if (load_acc) begin
      if (room) begin
        if (keep) begin
          pos_nxt = pos_inc;
        end
        if (end_str) begin
          cnt_nxt = cnt_r + CW'(1);
          pos_nxt = '0;
        end
      end else begin
        pos_nxt = '0;
      end
    end
  end

  // ---------------- sort datapath ----------------
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (ctrl.op == sesort_pkg::OP_PUSH) && out_free;

  // Bytes past a string's stored length read as zero, which ends the compare.
  assign x_byte = (k_r < la_r) ? ta_r : '0;
  assign y_byte = (k_r < lb_r) ? tb_r : '0;

  assign ta_addr = AW'(oi_r) * AW'(MAX_LEN) + AW'(k_r);
  assign tb_addr = AW'(oj_r) * AW'(MAX_LEN) + AW'(k_r);
  assign text_re = (ctrl.op == sesort_pkg::OP_LD_LB);

  assign len_re    = (ctrl.op == sesort_pkg::OP_LD_OJ) || (ctrl.op == sesort_pkg::OP_LD_LA);
  assign len_raddr = (ctrl.op == sesort_pkg::OP_LD_LA) ? oj_r : oi_r;

  assign ord_re    = (ctrl.op == sesort_pkg::OP_RD_OI) || (ctrl.op == sesort_pkg::OP_RD_OJ) ||
                     (ctrl.op == sesort_pkg::OP_RD_OUT);
  assign ord_raddr = (ctrl.op == sesort_pkg::OP_RD_OJ) ? j_r[IW-1:0] : i_r[IW-1:0];

  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    oi_nxt    = oi_r;
    oj_nxt    = oj_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    gt_nxt    = gt_r;
    ord_we    = 1'b0;
    ord_waddr = i_r[IW-1:0];
    ord_wdata = i_r[IW-1:0];
    case (ctrl.op)
      sesort_pkg::OP_CLR_I: begin
        i_nxt = '0;
      end
      sesort_pkg::OP_INIT_ORD: begin
        ord_we = 1'b1;
        i_nxt  = i_r + CW'(1);
      end
      sesort_pkg::OP_RD_OI: begin
        j_nxt = i_r + CW'(1);
      end
      sesort_pkg::OP_LD_OI: begin
        oi_nxt = ord_rd_r;
      end
      sesort_pkg::OP_LD_OJ: begin
        oj_nxt = ord_rd_r;
        k_nxt  = '0;
      end
      sesort_pkg::OP_LD_LA: begin
        la_nxt = len_rd_r;
      end
      sesort_pkg::OP_LD_LB: begin
        lb_nxt = len_rd_r;
      end
      sesort_pkg::OP_CMP: begin
        gt_nxt = x_byte > y_byte;
        k_nxt  = k_r + LW'(1);
      end
      sesort_pkg::OP_SWAP_I: begin
        ord_we    = 1'b1;
        ord_wdata = oj_r;
      end
      sesort_pkg::OP_SWAP_J: begin
        ord_we    = 1'b1;
        ord_waddr = j_r[IW-1:0];
        ord_wdata = oi_r;
        oi_nxt    = oj_r;
      end
      sesort_pkg::OP_INC_J: begin
        j_nxt = j_r + CW'(1);
      end
      sesort_pkg::OP_INC_I: begin
        i_nxt = i_r + CW'(1);
      end
      sesort_pkg::OP_PUSH: begin
        if (out_free) begin
          i_nxt = i_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    oi_r <= oi_nxt;
    oj_r <= oj_nxt;
    la_r <= la_nxt;
    lb_r <= lb_nxt;
    gt_r <= gt_nxt;
    if (push) begin
      out_idx_r  <= OW'(ord_rd_r);
      out_last_r <= ({1'b0, i_r} + (CW + 1)'(1)) == {1'b0, cnt_r};
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_waddr] <= in_char_code;
    end
    if (text_re) begin
      ta_r <= text_mem[ta_addr];
      tb_r <= text_mem[tb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[ld_idx] <= keep ? pos_inc : pos_r;
    end
    if (len_re) begin
      len_rd_r <= len_mem[len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd_r <= ord_mem[ord_raddr];
    end
  end

  // ---------------- status and outputs ----------------
  assign stat.start     = in_valid && in_last_of_set && !ctrl.busy;
  assign stat.init_more = ({1'b0, i_r} + (CW + 1)'(1)) != {1'b0, cnt_r};
  assign stat.n_one     = (cnt_r == CW'(1));
  assign stat.cont      = (x_byte == y_byte) && (x_byte != '0);
  assign stat.gt        = gt_r;
  assign stat.j_more    = ({1'b0, j_r} + (CW + 1)'(1)) != {1'b0, cnt_r};
  assign stat.i_more    = ({1'b0, i_r} + (CW + 1)'(2)) != {1'b0, cnt_r};
  assign stat.out_busy  = !out_free;
  assign stat.emit_more = (i_r != cnt_r);

  assign out_valid        = out_valid_r;
  assign out_string_index = out_idx_r;
  assign out_last_of_run  = out_last_r;

  a_cmp_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == sesort_pkg::OP_CMP |-> (k_r <= la_r) && (k_r <= lb_r))
    else $error("byte compare ran past both string lengths");

  a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == sesort_pkg::OP_PUSH |-> i_r < cnt_r)
    else $error("result pushed beyond the loaded string count");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for string_exchange_sort_top: streams strings in a word at a time
// and checks each sorted index word against an exchange sort computed alongside.
// Depends on sesort_pkg and the string_exchange_sort_top RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NSTR = sesort_pkg::MAX_STRINGS_DEF;
  localparam int SLEN = sesort_pkg::MAX_LEN_DEF;
  localparam int RANDOM_WORDS = 410;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    logic       eoset;
    bit         drain;
  } char_word_t;

  typedef struct {
    logic [2:0] idx;
    logic       last;
  } rank_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_code = '0;
  logic in_last_of_string = 1'b0;
  logic in_last_of_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_string_index;
  logic out_last_of_run;

  char_word_t word_q[$];
  rank_t      rank_q[$];
  int         total_words;
  int         words_taken = 0;
  int         err_cnt = 0;

  // Shadow copy of the string buffers.
  logic [7:0] text_buf [NSTR][SLEN];
  int         str_len [NSTR];
  int         str_cnt = 0;
  int         char_pos = 0;

  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int calm_left = 0;
  bit long_hold_done = 1'b0;

  string_exchange_sort_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_of_string(in_last_of_string),
    .in_last_of_set   (in_last_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_string_index (out_string_index),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  // strcmp on unsigned bytes; bytes past the stored length read as zero.
  function automatic bit str_after(input int a, input int b);
    logic [7:0] x, y;
    for (int k = 0; k < SLEN; k++) begin
      x = (k < str_len[a]) ? text_buf[a][k] : 8'd0;
      y = (k < str_len[b]) ? text_buf[b][k] : 8'd0;
      if (x != y) return x > y;
      if (x == 8'd0) return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic load_word(input logic [7:0] ch, input logic eos, input logic eoset);
    int    order [NSTR];
    int    t;
    rank_t r;
    if (str_cnt < NSTR) begin
      if (char_pos < SLEN - 1) begin
        text_buf[str_cnt][char_pos] = ch;
        char_pos++;
      end
      if (eos || eoset) begin
        str_len[str_cnt] = char_pos;
        str_cnt++;
        char_pos = 0;
      end
    end else begin
      char_pos = 0;
    end
    if (eoset) begin
      for (int i = 0; i < str_cnt; i++) order[i] = i;
      for (int i = 0; i + 1 < str_cnt; i++) begin
        for (int j = i + 1; j < str_cnt; j++) begin
          if (str_after(order[i], order[j])) begin
            t = order[i];
            order[i] = order[j];
            order[j] = t;
          end
        end
      end
      for (int i = 0; i < str_cnt; i++) begin
        r.idx  = order[i][2:0];
        r.last = (i == str_cnt - 1);
        rank_q.push_back(r);
      end
      str_cnt = 0;
      char_pos = 0;
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones, and gap-free bursts.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin : word_driver
    char_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        load_word(in_char_code, in_last_of_string, in_last_of_set);
        words_taken++;
        gap_left = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0 && !(word_q[0].drain && rank_q.size() > 0)) begin
          w = word_q.pop_front();
          in_char_code      <= w.ch;
          in_last_of_string <= w.eos;
          in_last_of_set    <= w.eoset;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver pacing; one long hold-off once a sort is under way, so the input backs up.
  always @(posedge clk) begin : result_pacing
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && words_taken > 100 && rank_q.size() > 0) begin
      long_hold_done = 1'b1;
      hold_left = 500;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        calm_left = $urandom_range(40, 150);
        out_stall <= 1'b0;
      end else if (r < 10) begin
        hold_left = $urandom_range(8, 30);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (r < 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rank_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rank_q.size() == 0) begin
        report_mismatch("index word with none expected", out_string_index, -1);
      end else begin
        want = rank_q.pop_front();
        if (out_string_index !== want.idx)
          report_mismatch("string_index", out_string_index, want.idx);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  task automatic add_word(input logic [7:0] ch, input logic eos, input logic eoset,
                          input bit drain);
    char_word_t w;
    w.ch = ch;
    w.eos = eos;
    w.eoset = eoset;
    w.drain = drain;
    word_q.push_back(w);
  endtask

  function automatic logic [7:0] pick_char(input int mode);
    int r;
    if (mode == 0) return 8'd97 + 8'($urandom_range(0, 2));
    if (mode == 1) return 8'($urandom_range(0, 255));
    r = $urandom_range(0, 4);
    case (r)
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'd97;
    endcase
  endfunction

  // A set of strings with random content; small alphabets make shared prefixes and ties likely.
  task automatic add_set(input bit force_long);
    int  n, len, mode, r;
    bit  fin, drain;
    n = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8) : $urandom_range(9, 11);
    drain = ($urandom_range(0, 4) == 0);
    for (int s = 0; s < n; s++) begin
      fin = (s == n - 1);
      r = $urandom_range(0, 99);
      if ((force_long && s == 0) || r < 4) len = (force_long && s == 0) ? 70 : $urandom_range(60, 70);
      else len = $urandom_range(1, 5);
      r = $urandom_range(0, 9);
      mode = (r < 7) ? 0 : (r < 9) ? 1 : 2;
      for (int k = 0; k < len; k++) begin
        add_word(pick_char(mode),
                 (k == len - 1) && (!fin || $urandom_range(0, 1)),
                 (k == len - 1) && fin,
                 drain && s == 0 && k == 0);
      end
    end
  endtask

  initial begin : run_control
    int first_random;
    // A lone empty string that also closes the set without a string flag.
    add_word(8'd0, 1'b0, 1'b1, 1'b0);
    // Extreme bytes, a prefix pair, equal strings and an empty string.
    add_word(8'd255, 1'b1, 1'b0, 1'b1);
    add_word("a", 1'b1, 1'b0, 1'b0);
    add_word("a", 1'b0, 1'b0, 1'b0);
    add_word("b", 1'b1, 1'b0, 1'b0);
    add_word("a", 1'b1, 1'b0, 1'b0);
    add_word(8'd0, 1'b1, 1'b0, 1'b0);
    add_word("b", 1'b1, 1'b1, 1'b0);
    // Nine strings in descending order; the ninth and the closing word are not stored.
    for (int s = 0; s < 9; s++) add_word(8'd105 - 8'(s), 1'b1, 1'b0, s == 0);
    add_word("z", 1'b0, 1'b1, 1'b0);

    first_random = word_q.size();
    add_set(1'b1);
    while (word_q.size() - first_random < RANDOM_WORDS) add_set(1'b0);
    total_words = word_q.size();

    while (words_taken < total_words || rank_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
